/* rtl/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared widths, register map, reset values and types for the triple-click
// detector.
// ----------------------------------------------------------------------------
package tcd_pkg;

   localparam int TimeW   = 32;
   localparam int IntvW   = 8;
   localparam int WinW    = 16;
   localparam int PressW  = 8;
   localparam int ClicksW = 3;
   localparam int CsrIdxW = 3;
   localparam int CsrDatW = 16;

   // register map
   localparam logic [CsrIdxW-1:0] RegSampleIntv = 3'd0;
   localparam logic [CsrIdxW-1:0] RegWindow     = 3'd1;
   localparam logic [CsrIdxW-1:0] RegMinPress   = 3'd2;
   localparam logic [CsrIdxW-1:0] RegMaxPress   = 3'd3;
   localparam logic [CsrIdxW-1:0] RegClicksNeed = 3'd4;

   // reset values
   localparam logic [IntvW-1:0]   RstSampleIntv = 8'd10;
   localparam logic [WinW-1:0]    RstWindow     = 16'd2000;
   localparam logic [PressW-1:0]  RstMinPress   = 8'd4;
   localparam logic [PressW-1:0]  RstMaxPress   = 8'd30;
   localparam logic [ClicksW-1:0] RstClicksNeed = 3'd3;

   localparam logic [PressW-1:0]  PressMax      = 8'hff;
   localparam logic [ClicksW-1:0] ClicksFloor   = 3'd2;

   typedef struct packed {
      logic [IntvW-1:0]   sample_intv;
      logic [WinW-1:0]    window;
      logic [PressW-1:0]  min_press;
      logic [PressW-1:0]  max_press;
      logic [ClicksW-1:0] clicks_need;
   } cfg_type;

   typedef struct packed {
      logic [TimeW-1:0] now_ms;
      logic             cpu_idle;
      logic             key_held;
   } sample_type;

   typedef struct packed {
      logic               detected;
      logic [ClicksW-1:0] clicks_seen;
   } result_type;

endpackage

/* rtl/triple_click_detector.sv */
// ----------------------------------------------------------------------------
// triple_click_detector
// Detects a sequence of timed key clicks sampled while a processor is idle.
// ----------------------------------------------------------------------------
// Pipeline: the accepted sample is held in the input register, then
//   evaluated into the result register; a stalled result holds both.
// Throughput: one item per cycle while the result side is not stalled;
//   the evaluate-and-update path of the sequence state is combinational.
// Reset: synchronous; clears both pipeline valids, the sequence state and
//   loads the configuration defaults.
module triple_click_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tcd_pkg::TimeW-1:0]           req_now_ms,
   input  logic                                req_cpu_idle,
   input  logic                                req_key_held,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_detected,
   output logic [tcd_pkg::ClicksW-1:0]         rsp_clicks_seen,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcd_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [tcd_pkg::CsrDatW-1:0]         csr_wdata
);

   tcd_pkg::cfg_type    cfg;
   tcd_pkg::sample_type smp_ff, smp_in;
   tcd_pkg::result_type res;
   tcd_pkg::result_type res_ff;
   logic                in_v_ff, in_v_in;
   logic                out_v_ff, out_v_in;
   logic                advance;
   logic                step;
   logic                take;

   tcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tcd_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (step),
      .smp   (smp_ff),
      .res   (res)
   );

   assign advance   = !out_v_ff || !rsp_stall;
   assign step      = in_v_ff && advance;
   assign req_stall = in_v_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign smp_in.now_ms   = req_now_ms;
   assign smp_in.cpu_idle = req_cpu_idle;
   assign smp_in.key_held = req_key_held;

   assign in_v_in  = take || (in_v_ff && !advance);
   assign out_v_in = step || (out_v_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         smp_ff <= smp_in;
      end
      if (step) begin
         res_ff <= res;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_detected    = res_ff.detected;
   assign rsp_clicks_seen = res_ff.clicks_seen;

endmodule

/* rtl/tcd_csr.sv */
// ----------------------------------------------------------------------------
// tcd_csr
// Configuration registers, written through a valid/ready port.
// ----------------------------------------------------------------------------
module tcd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [tcd_pkg::CsrDatW-1:0]   csr_wdata,
   output tcd_pkg::cfg_type              cfg
);

   tcd_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tcd_pkg::RegSampleIntv: cfg_in.sample_intv = csr_wdata[tcd_pkg::IntvW-1:0];
            tcd_pkg::RegWindow:     cfg_in.window      = csr_wdata[tcd_pkg::WinW-1:0];
            tcd_pkg::RegMinPress:   cfg_in.min_press   = csr_wdata[tcd_pkg::PressW-1:0];
            tcd_pkg::RegMaxPress:   cfg_in.max_press   = csr_wdata[tcd_pkg::PressW-1:0];
            tcd_pkg::RegClicksNeed: cfg_in.clicks_need = csr_wdata[tcd_pkg::ClicksW-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_intv <= tcd_pkg::RstSampleIntv;
         cfg_ff.window      <= tcd_pkg::RstWindow;
         cfg_ff.min_press   <= tcd_pkg::RstMinPress;
         cfg_ff.max_press   <= tcd_pkg::RstMaxPress;
         cfg_ff.clicks_need <= tcd_pkg::RstClicksNeed;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/tcd_core.sv */
// ----------------------------------------------------------------------------
// tcd_core
// Sequence state and single-pass evaluation of one sample.
// ----------------------------------------------------------------------------
module tcd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  tcd_pkg::cfg_type     cfg,
   input  logic                 step,
   input  tcd_pkg::sample_type  smp,
   output tcd_pkg::result_type  res
);

   logic [tcd_pkg::TimeW-1:0]   last_ms_ff,  last_ms_in;
   logic [tcd_pkg::TimeW-1:0]   first_ms_ff, first_ms_in;
   logic [tcd_pkg::PressW-1:0]  press_ff,    press_in;
   logic                        active_ff,   active_in;
   logic [tcd_pkg::ClicksW-1:0] count_ff,    count_in;
   logic                        det;
   logic [tcd_pkg::TimeW-1:0]   due_ms;
   logic [tcd_pkg::TimeW-1:0]   expiry_ms;
   logic [tcd_pkg::ClicksW-1:0] count_inc;
   logic [tcd_pkg::ClicksW-1:0] need_eff;

   assign due_ms    = last_ms_ff + {{(tcd_pkg::TimeW-tcd_pkg::IntvW){1'b0}}, cfg.sample_intv};
   assign expiry_ms = first_ms_ff + {{(tcd_pkg::TimeW-tcd_pkg::WinW){1'b0}}, cfg.window};
   assign count_inc = count_ff + 3'd1;
   // needed counts below two behave as two
   assign need_eff  = (cfg.clicks_need < tcd_pkg::ClicksFloor) ? tcd_pkg::ClicksFloor
                                                               : cfg.clicks_need;

   always_comb begin
      last_ms_in  = last_ms_ff;
      first_ms_in = first_ms_ff;
      press_in    = press_ff;
      active_in   = active_ff;
      count_in    = count_ff;
      det         = 1'b0;
      if (due_ms <= smp.now_ms) begin
         last_ms_in = smp.now_ms;
         if (active_ff && (expiry_ms < smp.now_ms)) begin
            press_in  = '0;
            active_in = 1'b0;
            count_in  = '0;
         end else if (!smp.cpu_idle) begin
            // busy: sample consumed, nothing else
         end else if (smp.key_held) begin
            if (press_ff != tcd_pkg::PressMax) begin
               press_in = press_ff + 8'd1;
            end
         end else if (press_ff == '0) begin
            // no press pending
         end else if (press_ff < cfg.min_press) begin
            press_in = '0;
         end else if (press_ff > cfg.max_press) begin
            press_in  = '0;
            active_in = 1'b0;
            count_in  = '0;
         end else if (!active_ff) begin
            active_in   = 1'b1;
            count_in    = 3'd1;
            first_ms_in = smp.now_ms;
            press_in    = '0;
         end else begin
            press_in = '0;
            count_in = count_inc;
            if (count_inc >= need_eff) begin
               active_in = 1'b0;
               count_in  = '0;
               det       = 1'b1;
            end
         end
      end
   end

   assign res.detected    = det;
   assign res.clicks_seen = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ms_ff  <= '0;
         first_ms_ff <= '0;
         press_ff    <= '0;
         active_ff   <= 1'b0;
         count_ff    <= '0;
      end else if (step) begin
         last_ms_ff  <= last_ms_in;
         first_ms_ff <= first_ms_in;
         press_ff    <= press_in;
         active_ff   <= active_in;
         count_ff    <= count_in;
      end
   end

endmodule

/* rtl/tcd_checker.sv */
// ----------------------------------------------------------------------------
// tcd_port_checks
// Port-level checks on the triple-click detector.
// ----------------------------------------------------------------------------
module tcd_port_checks (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_detected,
   input logic [tcd_pkg::ClicksW-1:0] rsp_clicks_seen
);

   // a completed sequence always reports an emptied count
   a_det_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detected |-> rsp_clicks_seen == '0)
      else $error("detected without cleared click count");

   // input only backs up when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_detected)
                                && $stable(rsp_clicks_seen))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind triple_click_detector tcd_port_checks u_port_checks (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_detected    (rsp_detected),
   .rsp_clicks_seen (rsp_clicks_seen)
);

/* verif/tcd_checker.sv */
// ----------------------------------------------------------------------------
// tcd_checker
// Watches the sample, result and register channels of the triple-click
// detector, predicts the result of every accepted sample from its own copy
// of the sequence state and compares it with the result the block returns.
// ----------------------------------------------------------------------------
module tcd_checker
   import tcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [TimeW-1:0]   req_now_ms,
   input  logic               req_cpu_idle,
   input  logic               req_key_held,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_detected,
   input  logic [ClicksW-1:0] rsp_clicks_seen,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDatW-1:0] csr_wdata,
   output int unsigned        fail_cnt,
   output int unsigned        pending_cnt,
   output int unsigned        detect_cnt
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type            cfg;
   logic [TimeW-1:0]   last_ms;
   logic [TimeW-1:0]   first_ms;
   logic [PressW-1:0]  press_len;
   logic               seq_open;
   logic [ClicksW-1:0] clicks;
   result_type         due_q[$];

   task automatic restart_seq(input logic [TimeW-1:0] now);
      press_len = '0;
      seq_open  = 1'b0;
      clicks    = '0;
      last_ms   = now;
   endtask

   task automatic judge_sample(input sample_type s, output result_type r);
      logic [TimeW-1:0] due;
      logic             det;
      det = 1'b0;
      // both time sums wrap at 32 bits, compared unsigned
      due = last_ms + TimeW'(cfg.sample_intv);
      if (due <= s.now_ms) begin
         last_ms = s.now_ms;
         // window check comes ahead of the idle check
         if (seq_open && (first_ms + TimeW'(cfg.window)) < s.now_ms) begin
            restart_seq(s.now_ms);
         end else if (s.cpu_idle) begin
            if (s.key_held) begin
               if (press_len != PressMax) press_len = press_len + 1'b1;
            end else if (press_len != '0) begin
               if (press_len < cfg.min_press) begin
                  press_len = '0;
               end else if (press_len > cfg.max_press) begin
                  restart_seq(s.now_ms);
               end else if (!seq_open) begin
                  seq_open  = 1'b1;
                  clicks    = 3'd1;
                  first_ms  = s.now_ms;
                  press_len = '0;
               end else begin
                  clicks    = clicks + 1'b1;
                  press_len = '0;
                  // a needed count below two behaves as two
                  if (clicks >= cfg.clicks_need ||
                      (clicks >= 3'd2 && cfg.clicks_need < 3'd2)) begin
                     restart_seq(s.now_ms);
                     det = 1'b1;
                  end
               end
            end
         end
      end
      r.detected    = det;
      r.clicks_seen = clicks;
   endtask

   // All inputs change just after a rising edge, so the levels seen at the
   // falling edge are the ones the block takes at the next rising edge.
   always @(negedge clock) begin
      sample_type s;
      result_type want;
      result_type got;
      if (reset) begin
         cfg.sample_intv = RstSampleIntv;
         cfg.window      = RstWindow;
         cfg.min_press   = RstMinPress;
         cfg.max_press   = RstMaxPress;
         cfg.clicks_need = RstClicksNeed;
         last_ms   = '0;
         first_ms  = '0;
         press_len = '0;
         seq_open  = 1'b0;
         clicks    = '0;
         due_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               $display("%0t: result with no sample waiting, detected %b clicks_seen %0d",
                        $time, rsp_detected, rsp_clicks_seen);
               fail_cnt++;
            end else begin
               want = due_q.pop_front();
               got.detected    = rsp_detected;
               got.clicks_seen = rsp_clicks_seen;
               if (got.detected !== want.detected) begin
                  $display("%0t: detected mismatch, expected %b, actual %b",
                           $time, want.detected, got.detected);
               end
               if (got.clicks_seen !== want.clicks_seen) begin
                  $display("%0t: clicks_seen mismatch, expected %0d, actual %0d",
                           $time, want.clicks_seen, got.clicks_seen);
               end
               if (got !== want) fail_cnt++;
               if (got.detected === 1'b1) detect_cnt++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegSampleIntv: cfg.sample_intv = csr_wdata[IntvW-1:0];
               RegWindow:     cfg.window      = csr_wdata[WinW-1:0];
               RegMinPress:   cfg.min_press   = csr_wdata[PressW-1:0];
               RegMaxPress:   cfg.max_press   = csr_wdata[PressW-1:0];
               RegClicksNeed: cfg.clicks_need = csr_wdata[ClicksW-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            s.now_ms   = req_now_ms;
            s.cpu_idle = req_cpu_idle;
            s.key_held = req_key_held;
            judge_sample(s, want);
            due_q.push_back(want);
         end
      end
      pending_cnt = due_q.size();
   end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the triple-click detector: a short scripted run
// at reset settings, then random click gestures and noise under a series of
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcd_pkg::*;

   localparam int unsigned CycleLimit    = 600000;
   localparam int          HoldOffCycles = 300;

   typedef enum int {StallNone, StallRandom, StallLong, StallHoldOff} stall_mode_type;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_stall;
   logic [TimeW-1:0]   req_now_ms   = '0;
   logic               req_cpu_idle = 1'b0;
   logic               req_key_held = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall    = 1'b0;
   logic               rsp_detected;
   logic [ClicksW-1:0] rsp_clicks_seen;
   logic               csr_valid    = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index    = '0;
   logic [CsrDatW-1:0] csr_wdata    = '0;

   int unsigned fail_cnt;
   int unsigned pending_cnt;
   int unsigned detect_cnt;
   int unsigned cycle_cnt     = 0;
   int unsigned items_sent    = 0;
   int unsigned settings_cnt  = 0;
   int unsigned hold_offs     = 0;
   int unsigned hold_off_reqs = 0;
   bit          tight         = 1'b0;
   logic [TimeW-1:0] t_ms     = '0;

   // current settings, kept only to shape the stimulus
   int cur_intv   = 10;
   int cur_window = 2000;
   int cur_min    = 4;
   int cur_max    = 30;
   int cur_need   = 3;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   triple_click_detector u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ms      (req_now_ms),
      .req_cpu_idle    (req_cpu_idle),
      .req_key_held    (req_key_held),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_detected    (rsp_detected),
      .rsp_clicks_seen (rsp_clicks_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   tcd_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_now_ms      (req_now_ms),
      .req_cpu_idle    (req_cpu_idle),
      .req_key_held    (req_key_held),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_detected    (rsp_detected),
      .rsp_clicks_seen (rsp_clicks_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_cnt        (fail_cnt),
      .pending_cnt     (pending_cnt),
      .detect_cnt      (detect_cnt)
   );

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CycleLimit) begin
         $display("triple_click_detector verification failed");
         $finish;
      end
   end

   // result side back-pressure: quiet runs, random stalls, long stalls and
   // the requested hold-offs
   initial begin : stall_gen
      int             left;
      int             r;
      stall_mode_type mode;
      left = 0;
      mode = StallNone;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            r = $urandom_range(0, 9);
            if (hold_offs < hold_off_reqs) begin
               mode = StallHoldOff;
               left = HoldOffCycles;
               hold_offs++;
            end else if (r < 4) begin
               mode = StallNone;
               left = $urandom_range(10, 60);
            end else if (r < 9) begin
               mode = StallRandom;
               left = $urandom_range(1, 40);
            end else begin
               mode = StallLong;
               left = $urandom_range(5, 30);
            end
         end
         case (mode)
            StallNone:   rsp_stall <= 1'b0;
            StallRandom: rsp_stall <= ($urandom_range(0, 9) < 3);
            default:     rsp_stall <= 1'b1;
         endcase
         left--;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tight || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // valid stays high on return so back-to-back items need no re-raise
   task automatic send_sample(input logic [TimeW-1:0] now, input logic idle,
                              input logic held);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_now_ms   <= now;
      req_cpu_idle <= idle;
      req_key_held <= held;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic advance(input bit noisy);
      int r;
      r = $urandom_range(0, 99);
      if (!noisy || r < 70) t_ms = t_ms + cur_intv;
      else if (r < 85) t_ms = t_ms + cur_intv + $urandom_range(1, 5);
      else t_ms = t_ms + $urandom_range(0, cur_intv - 1);
   endtask

   // press length in samples, mostly near the accepted limits
   function automatic int pick_press();
      int r;
      int lo;
      int hi;
      r  = $urandom_range(0, 99);
      lo = (cur_min < 1) ? 1 : cur_min;
      hi = (cur_max < lo + 12) ? cur_max : lo + 12;
      // very long limits: keep presses cheap, all of them too short
      if (lo > 40) return $urandom_range(1, 40);
      if (r < 65 && hi >= lo) return $urandom_range(lo, hi);
      if (r < 82 && lo > 1) return $urandom_range((lo > 4) ? lo - 3 : 1, lo - 1);
      if (cur_max > 40) return $urandom_range(lo, (hi >= lo) ? hi : lo);
      return cur_max + $urandom_range(1, 3);
   endfunction

   task automatic tap(input int held_n, input int rel_n, input bit noisy);
      for (int i = 0; i < held_n; i++) begin
         advance(noisy);
         send_sample(t_ms, noisy ? logic'($urandom_range(0, 9) != 0) : 1'b1, 1'b1);
      end
      for (int i = 0; i < rel_n; i++) begin
         advance(noisy);
         send_sample(t_ms, noisy ? logic'($urandom_range(0, 9) != 0) : 1'b1, 1'b0);
      end
   endtask

   task automatic run_gesture();
      int n;
      n = $urandom_range(1, (cur_need < 2) ? 3 : cur_need + 1);
      tight = ($urandom_range(0, 9) < 3);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 24) == 0) begin
            // step past the window so the open sequence times out
            t_ms = t_ms + cur_window + $urandom_range(1, 50);
            send_sample(t_ms, logic'($urandom_range(0, 1)), 1'b0);
         end
         tap(pick_press(), $urandom_range(1, 4), 1'b1);
      end
      tight = 1'b0;
   endtask

   task automatic run_noise();
      int               n;
      logic [TimeW-1:0] stamp;
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 2 && t_ms > 300) begin
            // stale time stamp, too early to be evaluated
            stamp = t_ms - $urandom_range(1, 300);
         end else begin
            t_ms  = t_ms + $urandom_range(0, 2 * cur_intv);
            stamp = t_ms;
         end
         send_sample(stamp, logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cnt != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx,
                            input logic [CsrDatW-1:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
   endtask

   // unused upper data bits carry noise
   task automatic set_config(input int intv, input int window, input int min_p,
                             input int max_p, input int need);
      write_reg(RegSampleIntv, {8'($urandom), 8'(intv)});
      write_reg(RegWindow, 16'(window));
      write_reg(RegMinPress, {8'($urandom), 8'(min_p)});
      write_reg(RegMaxPress, {8'($urandom), 8'(max_p)});
      write_reg(RegClicksNeed, {13'($urandom), 3'(need)});
      csr_valid <= 1'b0;
      cur_intv   = intv;
      cur_window = window;
      cur_min    = min_p;
      cur_max    = max_p;
      cur_need   = need;
      settings_cnt++;
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) run_gesture();
         else run_noise();
      end
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: wrapped due time, then three clicks with a busy sample
      send_sample(32'd0, 1'b1, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_sample(32'd4, 1'b1, 1'b1);
      send_sample(32'd9, 1'b1, 1'b1);
      t_ms = 32'd9;
      tap(3, 1, 1'b0);
      t_ms = t_ms + 10;
      send_sample(t_ms, 1'b0, 1'b1);
      tap(4, 1, 1'b0);
      tap(4, 1, 1'b0);
      // click near the top of time: the window sum wraps, busy sample times out
      t_ms = 32'hFFFF_FF00;
      send_sample(t_ms, 1'b1, 1'b0);
      tap(4, 1, 1'b0);
      t_ms = t_ms + 10;
      send_sample(t_ms, 1'b0, 1'b0);
      // leaves the next due time wrapped to just above zero
      send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
      settle();
      t_ms = '0;

      set_config(1, 65535, 1, 255, 7);
      hold_off_reqs++;
      while (hold_offs == 0) @(posedge clock);
      tight = 1'b1;
      for (int i = 0; i < 40; i++) begin
         advance(1'b1);
         send_sample(t_ms, 1'b1, logic'($urandom_range(0, 1)));
      end
      tight = 1'b0;
      settle();
      // held long enough for the press length to saturate
      tap(258, 1, 1'b0);
      run_phase(80);

      set_config(255, 1, 1, 1, 2);
      run_phase(90);
      set_config(5, 800, 6, 3, 3);      // crossed limits
      run_phase(100);
      set_config(3, 500, 0, 8, 4);      // zero minimum press
      run_phase(100);
      set_config(2, 300, 2, 6, 1);      // needed count below two
      run_phase(100);
      set_config(7, 65535, 3, 255, 0);
      run_phase(80);
      set_config(3, 1000, 255, 255, 2);
      run_phase(50);
      repeat (3) begin
         int m;
         m = $urandom_range(1, 6);
         set_config($urandom_range(1, 20), $urandom_range(100, 3000), m,
                    m + $urandom_range(0, 10), $urandom_range(2, 7));
         run_phase(90);
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Ran %0d samples under %0d register settings plus reset values,",
               items_sent, settings_cnt);
      $display("with %0d detections and %0d long result hold-offs.",
               detect_cnt, hold_offs);
      if (fail_cnt == 0) begin
         $display("triple_click_detector verification clean");
      end else begin
         $display("triple_click_detector verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/tcd_pkg.sv
rtl/tcd_csr.sv
rtl/tcd_core.sv
rtl/triple_click_detector.sv
rtl/tcd_checker.sv
verif/tcd_checker.sv
verif/tb.sv
